// ===== hdl/trial_division_prime_check_unit_defines.svh =====
// Assertion macros for the trial division prime check unit.
`ifndef TRIAL_DIVISION_PRIME_CHECK_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_CHECK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge, masked while reset is asserted.
`define TDPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define TDPC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TDPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDPC_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hdl/tdpc_pkg.sv =====
package tdpc_pkg;

	// width of the input value, sign bit included
	localparam int VALUE_WIDTH = 32;
	// magnitude bits of a non-negative value
	localparam int MAG_W = VALUE_WIDTH - 1;
	// trial divisor never exceeds sqrt(2^MAG_W) + 2
	localparam int DIV_W = VALUE_WIDTH / 2 + 1;
	// divisor squared
	localparam int SQ_W = 2 * DIV_W;
	// bit index into the magnitude
	localparam int CNT_W = $clog2(MAG_W);
	// odd divisors advance by this
	localparam int DIV_STEP = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/trial_division_prime_check_unit.sv =====
// Trial division prime check: one transaction in, one result strobe out.
// Negative, 0..3 and even values go from idle straight to the finish state.
// Odd v >= 5 tries odd divisors: a compare state, then a remainder pass over
// all 31 magnitude bits, until d*d > v (prime) or a divisor leaves no remainder.
// A new start is taken in the cycle after done; the receiver cannot stall.
// Reset: arst_n asynchronous active low returns the sequencer to idle.
`include "trial_division_prime_check_unit_defines.svh"

module trial_division_prime_check_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [tdpc_pkg::VALUE_WIDTH-1:0] value,
	output logic                                   done,
	output logic                                   is_prime,
	output logic                                   is_power_of_two,
	output logic                                   both_true
);

	localparam int MAG_W = tdpc_pkg::MAG_W;
	localparam int DIV_W = tdpc_pkg::DIV_W;
	localparam int SQ_W  = tdpc_pkg::SQ_W;
	localparam int CNT_W = tdpc_pkg::CNT_W;
	localparam int VW    = tdpc_pkg::VALUE_WIDTH;

	// Control state
	tdpc_pkg::state_t state_q, state_d;

	// Datapath registers (no reset needed)
	logic [MAG_W-1:0] v_q, v_d;       // magnitude under test
	logic [DIV_W-1:0] d_q, d_d;       // current odd trial divisor
	logic [SQ_W-1:0]  sq_q, sq_d;     // d_q squared, kept incrementally
	logic [DIV_W:0]   rem_q, rem_d;   // partial remainder, always < d_q
	logic [CNT_W-1:0] cnt_q, cnt_d;   // next magnitude bit to shift in
	logic             prime_q, prime_d;
	logic             pow2_q, pow2_d;

	// Shared remainder step: shift in one bit, conditionally subtract d.
	logic [VW-1:0]  raw;
	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_nx;
	logic           pow2_raw;

	assign raw    = value;
	assign rem_sh = {rem_q[DIV_W-1:0], v_q[cnt_q]};
	assign rem_nx = (rem_sh >= {1'b0, d_q}) ? (rem_sh - {1'b0, d_q}) : rem_sh;

	// Positive with a single bit set
	assign pow2_raw = !raw[VW-1] && (raw != '0) && ((raw & (raw - VW'(1))) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q     <= v_d;
		d_q     <= d_d;
		sq_q    <= sq_d;
		rem_q   <= rem_d;
		cnt_q   <= cnt_d;
		prime_q <= prime_d;
		pow2_q  <= pow2_d;
	end

	always_comb begin
		state_d = state_q;
		v_d     = v_q;
		d_d     = d_q;
		sq_d    = sq_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		prime_d = prime_q;
		pow2_d  = pow2_q;
		done    = 1'b0;
		unique case (state_q)
			tdpc_pkg::ST_IDLE: begin
				if (start) begin
					v_d    = raw[MAG_W-1:0];
					pow2_d = pow2_raw;
					d_d    = DIV_W'(3);
					sq_d   = SQ_W'(9);
					if (raw[VW-1] || (raw < VW'(2))) begin
						// negative, zero, one
						prime_d = 1'b0;
						state_d = tdpc_pkg::ST_FINISH;
					end else if (raw < VW'(4)) begin
						// two and three
						prime_d = 1'b1;
						state_d = tdpc_pkg::ST_FINISH;
					end else if (!raw[0]) begin
						prime_d = 1'b0;
						state_d = tdpc_pkg::ST_FINISH;
					end else begin
						state_d = tdpc_pkg::ST_CHECK;
					end
				end
			end
			tdpc_pkg::ST_CHECK: begin
				if (sq_q > SQ_W'(v_q)) begin
					// divisor past the square root: no factor found
					prime_d = 1'b1;
					state_d = tdpc_pkg::ST_FINISH;
				end else begin
					rem_d   = '0;
					cnt_d   = CNT_W'(MAG_W - 1);
					state_d = tdpc_pkg::ST_DIV;
				end
			end
			tdpc_pkg::ST_DIV: begin
				rem_d = rem_nx;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					if (rem_nx == '0) begin
						prime_d = 1'b0;
						state_d = tdpc_pkg::ST_FINISH;
					end else begin
						// (d+2)^2 = d^2 + 4d + 4
						d_d     = d_q + DIV_W'(tdpc_pkg::DIV_STEP);
						sq_d    = sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
						state_d = tdpc_pkg::ST_CHECK;
					end
				end
			end
			tdpc_pkg::ST_FINISH: begin
				done    = 1'b1;
				state_d = tdpc_pkg::ST_IDLE;
			end
			default: begin
				state_d = tdpc_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy            = (state_q != tdpc_pkg::ST_IDLE);
	assign is_prime        = prime_q;
	assign is_power_of_two = pow2_q;
	assign both_true       = prime_q & pow2_q;

	// Assertions
	`TDPC_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accept did not raise busy")
	`TDPC_ASSERT(a_done_idle, clk, arst_n, done |=> !busy, "not idle after result strobe")
	`TDPC_ASSERT(a_div_odd, clk, arst_n, (state_q == tdpc_pkg::ST_DIV) |-> (d_q[0] && (rem_q < {1'b0, d_q})), "divisor even or remainder out of range")
	`TDPC_NEVER(a_both_two, clk, arst_n, done && both_true && (v_q != MAG_W'(2)), "both flags set for a value other than two")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the trial division prime check unit.
// One value goes in per start/busy transaction; one flag triple comes back
// on the done strobe. A local classifier predicts the flags and a checker
// compares each strobe against the oldest pending prediction.
module tb;

	typedef logic signed [tdpc_pkg::VALUE_WIDTH-1:0] val_t;

	// one predicted result
	typedef struct packed {
		logic prime;
		logic pow2;
		logic both;
	} flags_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	val_t value;
	logic done;
	logic is_prime;
	logic is_power_of_two;
	logic both_true;

	flags_t pending_flags[$];
	int errors;
	int n_sent;
	int n_checked;
	int n_prime;
	int n_pow2;
	int n_both;
	// while nonzero, the sender issues back to back with no idle cycles
	int burst_left;

	trial_division_prime_check_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.done            (done),
		.is_prime        (is_prime),
		.is_power_of_two (is_power_of_two),
		.both_true       (both_true)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Classify a value the way the block must: negatives are never prime or
	// a power of two; 0 and 1 are not prime; 2 and 3 are; other even values
	// are composite; odd values try odd divisors while d*d does not pass v.
	function automatic flags_t classify_value(input val_t v);
		longint unsigned mag;
		longint unsigned d;
		flags_t f;
		f = '0;
		mag = 0;
		if (v[tdpc_pkg::VALUE_WIDTH-1] == 1'b0) begin
			mag[tdpc_pkg::VALUE_WIDTH-1:0] = v;
			f.pow2 = (mag != 0) && ((mag & (mag - 1)) == 0);
			if (mag < 2)
				f.prime = 1'b0;
			else if (mag < 4)
				f.prime = 1'b1;
			else if (mag[0] == 1'b0)
				f.prime = 1'b0;
			else begin
				f.prime = 1'b1;
				d = 3;
				while (f.prime && d * d <= mag) begin
					if (mag % d == 0)
						f.prime = 1'b0;
					d += 2;
				end
			end
		end
		f.both = f.prime & f.pow2;
		return f;
	endfunction

	// idle cycles ahead of the next transaction
	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Issue one transaction: idle for a random gap, then hold start and the
	// value until an edge sees busy low. The prediction is queued at that edge.
	task automatic send_value(input val_t v);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_flags.push_back(classify_value(v));
		n_sent++;
	endtask

	task automatic wait_drained();
		while (pending_flags.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_flag(input string name, input logic exp_bit, input logic act_bit,
			input val_t v);
		if (act_bit !== exp_bit) begin
			errors++;
			$display("%0t: %s mismatch for value %0d: expected %b, actual %b",
				$time, name, v, exp_bit, act_bit);
		end
	endtask

	// Result checker: every done strobe must match the oldest prediction.
	// The value is kept only for the message, so it rides along in a side queue.
	val_t pending_vals[$];
	always @(posedge clk) begin
		flags_t exp_f;
		val_t exp_v;
		if (arst_n && done) begin
			if (pending_flags.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: expected none, actual %b%b%b",
					$time, is_prime, is_power_of_two, both_true);
			end else begin
				exp_f = pending_flags.pop_front();
				exp_v = pending_vals.pop_front();
				check_flag("is_prime", exp_f.prime, is_prime, exp_v);
				check_flag("is_power_of_two", exp_f.pow2, is_power_of_two, exp_v);
				check_flag("both_true", exp_f.both, both_true, exp_v);
				n_checked++;
				n_prime += exp_f.prime;
				n_pow2 += exp_f.pow2;
				n_both += exp_f.both;
			end
		end
	end

	// keep the message queue in step with the prediction queue
	task automatic send_and_log(input val_t v);
		pending_vals.push_back(v);
		send_value(v);
	endtask

	// Tiny values: the 0/1 not-prime case, 2 and 3, the even value 4, odd squares
	// where the divisor lands exactly on the square root.
	task automatic test_low_values();
		send_and_log(val_t'(0));
		send_and_log(val_t'(1));
		send_and_log(val_t'(2));
		send_and_log(val_t'(3));
		send_and_log(val_t'(4));
		send_and_log(val_t'(5));
		send_and_log(val_t'(9));
		send_and_log(val_t'(25));
		send_and_log(val_t'(97));
		send_and_log(val_t'(121));
	endtask

	// Powers of two: only 2 sets both flags; 65537 is a prime just above one.
	task automatic test_powers_of_two();
		send_and_log(val_t'(8));
		send_and_log(val_t'(65536));
		send_and_log(val_t'(65537));
		send_and_log(val_t'(32'h4000_0000));
	endtask

	// Sign handling and the ends of the range. The largest positive value is
	// prime, so it runs the full divisor sweep (the one long transaction).
	task automatic test_sign_extremes();
		send_and_log(val_t'(-1));
		send_and_log(val_t'(-2));
		send_and_log(val_t'(32'h8000_0000));
		send_and_log(val_t'(32'h7fff_fffe));
		send_and_log(val_t'(32'h7fff_fffd));
		send_and_log(val_t'(32'h7fff_ffff));
	endtask

	// Random value shaped to keep each transaction short: small values,
	// negatives, large evens, large multiples of three, powers of two and
	// squares of small numbers. All 32 bits get both polarities.
	function automatic val_t draw_value();
		val_t v;
		int unsigned sel;
		int unsigned p;
		sel = $urandom_range(0, 99);
		v = val_t'($urandom);
		if (sel < 35)
			v = val_t'($urandom_range(0, 4095));
		else if (sel < 50)
			v = val_t'($urandom_range(0, 65535) | 1);
		else if (sel < 65)
			v[tdpc_pkg::VALUE_WIDTH-1] = 1'b1;
		else if (sel < 75) begin
			v[tdpc_pkg::VALUE_WIDTH-1] = 1'b0;
			v[0] = 1'b0;
		end else if (sel < 85)
			v = val_t'(3 * $urandom_range(1, 715827882));
		else if (sel < 93)
			v = val_t'(32'd1 << $urandom_range(0, tdpc_pkg::VALUE_WIDTH - 2));
		else begin
			p = $urandom_range(2, 200);
			v = val_t'(p * p);
		end
		return v;
	endfunction

	// Pressure: send a few, stall until every result is back, then resume.
	task automatic test_drain_pause();
		repeat (4) send_and_log(draw_value());
		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (4) send_and_log(draw_value());
	endtask

	task automatic test_random_mix();
		repeat (72) begin
			if (burst_left == 0 && $urandom_range(0, 9) == 0)
				burst_left = $urandom_range(4, 10);
			send_and_log(draw_value());
		end
	endtask

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_prime = 0;
		n_pow2 = 0;
		n_both = 0;
		burst_left = 0;
		start = 1'b0;
		value = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_low_values();
		test_powers_of_two();
		test_sign_extremes();
		test_drain_pause();
		test_random_mix();

		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		// a stray strobe after the last result would show up here
		repeat (10) @(posedge clk);

		$display("%0d transactions sent, %0d results checked", n_sent, n_checked);
		$display("flags seen: %0d prime, %0d power of two, %0d both", n_prime, n_pow2,
			n_both);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog: ends a hung run with a failure message.
	initial begin
		#60000000;
		$display("tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tdpc_pkg.sv
hdl/trial_division_prime_check_unit.sv
bench/tb.sv
